/* hdl/cdcnt_pkg.sv */
// shared types, constants and calendar helper functions for the date counter
package cdcnt_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int MOD100_W = 7;
    localparam int CENT_W   = 2;
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 2;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;

    // classified item kinds handed from front to back
    localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BAD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FWD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOP  = 3'd4;

    // calendar limits
    localparam logic [YEAR_W-1:0]   YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0]  MONTH_MIN  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTHS     = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_MIN    = 5'd1;
    localparam logic [DAY_W-1:0]    DAY_LONG   = 5'd31;
    localparam logic [MOD100_W-1:0] MOD100_MAX = 7'd99;

    // reciprocal of 100 scaled by 2^19, exact quotient for years below 43690
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // one classified item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [MOD100_W-1:0] mod100;
        logic [CENT_W-1:0]   cent4;
    } t_cmd;

    // leap rule from year mod 4, year mod 100 and century mod 4
    function automatic logic leap_of(input logic [1:0] ylo,
                                     input logic [MOD100_W-1:0] m100,
                                     input logic [CENT_W-1:0] c4);
        return (ylo == 2'd0) && ((m100 != '0) || (c4 == '0));
    endfunction

    // days in a month, zero for a month out of range
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/cdcnt_front.sv */
// front end: accepts items, splits the load year and checks load dates
module cdcnt_front import cdcnt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [YEAR_W-1:0]    i_year,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [DAY_W-1:0]     i_day,
    output logic                 o_cmd_vld,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_rdy
);

    logic                 r_a_vld;
    logic [MODE_W-1:0]    r_a_mode;
    logic [YEAR_W-1:0]    r_a_year;
    logic [MONTH_W-1:0]   r_a_month;
    logic [DAY_W-1:0]     r_a_day;
    logic [7:0]           r_a_q;
    logic                 r_b_vld;
    t_cmd                 r_b_cmd;
    t_cmd                 n_b_cmd;

    logic [26:0]          w_prod;
    logic [YEAR_W-1:0]    w_hund;
    logic [YEAR_W-1:0]    w_rem;
    logic                 w_leap;
    logic [DAY_W-1:0]     w_len;
    logic                 w_ok;
    logic                 w_b_take;

    // stage handshakes
    assign w_b_take = !r_b_vld || i_cmd_rdy;
    assign o_ready  = !r_a_vld || w_b_take;

    // year divided by 100 through the scaled reciprocal
    assign w_prod = {13'd0, i_year} * {14'd0, RECIP_100};

    // stage a: capture item and quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_ready) begin
            r_a_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_mode  <= i_mode;
            r_a_year  <= i_year;
            r_a_month <= i_month;
            r_a_day   <= i_day;
            r_a_q     <= w_prod[RECIP_SHIFT +: 8];
        end
    end

    // remainder mod 100 and validity of a load
    assign w_hund = {r_a_q, 6'd0} + {1'b0, r_a_q, 5'd0} + {4'd0, r_a_q, 2'd0};
    assign w_rem  = r_a_year - w_hund;
    assign w_leap = leap_of(r_a_year[1:0], w_rem[MOD100_W-1:0], r_a_q[CENT_W-1:0]);
    assign w_len  = month_len(r_a_month, w_leap);
    assign w_ok   = (r_a_year >= YEAR_MIN) && (r_a_year <= YEAR_MAX)
                 && (r_a_month >= MONTH_MIN) && (r_a_month <= MONTHS)
                 && (r_a_day >= DAY_MIN) && (r_a_day <= w_len);

    // classify the item
    always_comb begin
        n_b_cmd.year   = r_a_year;
        n_b_cmd.month  = r_a_month;
        n_b_cmd.day    = r_a_day;
        n_b_cmd.mod100 = w_rem[MOD100_W-1:0];
        n_b_cmd.cent4  = r_a_q[CENT_W-1:0];
        case (r_a_mode)
            MODE_LOAD: n_b_cmd.kind = w_ok ? KIND_LOAD : KIND_BAD;
            MODE_FWD:  n_b_cmd.kind = KIND_FWD;
            MODE_BACK: n_b_cmd.kind = KIND_BACK;
            default:   n_b_cmd.kind = KIND_NOP;
        endcase
    end

    // stage b: classified item toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_take) begin
            r_b_vld <= r_a_vld;
        end
        if (w_b_take && r_a_vld) begin
            r_b_cmd <= n_b_cmd;
        end
    end

    assign o_cmd_vld = r_b_vld;
    assign o_cmd     = r_b_cmd;

endmodule

/* hdl/cdcnt_queue.sv */
// short queue of classified items between front and back
module cdcnt_queue import cdcnt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    output logic o_push_rdy,
    input  t_cmd i_push_cmd,
    output logic o_pop_vld,
    input  logic i_pop_rdy,
    output t_cmd o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_rdy = (r_count != CNT_W'(DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign w_push     = i_push_vld && o_push_rdy;
    assign w_pop      = o_pop_vld && i_pop_rdy;
    assign o_pop_cmd  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/cdcnt_back.sv */
// back end: holds the date, applies each item and registers the result
module cdcnt_back import cdcnt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_vld,
    output logic                 o_cmd_rdy,
    input  t_cmd                 i_cmd,
    output logic                 o_out_vld,
    input  logic                 i_out_rdy,
    output logic [YEAR_W-1:0]    o_year,
    output logic [MONTH_W-1:0]   o_month,
    output logic [DAY_W-1:0]     o_day,
    output logic                 o_leap,
    output logic                 o_month_end,
    output logic                 o_err
);

    // held date with year mod 100 and century mod 4 for the leap rule
    logic [YEAR_W-1:0]   r_year,   n_year;
    logic [MONTH_W-1:0]  r_month,  n_month;
    logic [DAY_W-1:0]    r_day,    n_day;
    logic [MOD100_W-1:0] r_mod100, n_mod100;
    logic [CENT_W-1:0]   r_cent4,  n_cent4;
    logic                n_err;
    logic                n_leap;
    logic                n_month_end;

    logic                r_out_vld;
    logic [YEAR_W-1:0]   r_out_year;
    logic [MONTH_W-1:0]  r_out_month;
    logic [DAY_W-1:0]    r_out_day;
    logic                r_out_leap;
    logic                r_out_month_end;
    logic                r_out_err;

    logic                w_leap_cur;
    logic [DAY_W-1:0]    w_len_cur;
    logic                w_fire;

    assign o_cmd_rdy  = !r_out_vld || i_out_rdy;
    assign w_fire     = i_cmd_vld && o_cmd_rdy;
    assign w_leap_cur = leap_of(r_year[1:0], r_mod100, r_cent4);
    assign w_len_cur  = month_len(r_month, w_leap_cur);

    // next date
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_mod100 = r_mod100;
        n_cent4  = r_cent4;
        n_err    = 1'b0;
        case (i_cmd.kind)
            KIND_LOAD: begin
                n_year   = i_cmd.year;
                n_month  = i_cmd.month;
                n_day    = i_cmd.day;
                n_mod100 = i_cmd.mod100;
                n_cent4  = i_cmd.cent4;
            end
            KIND_BAD: begin
                n_err = 1'b1;
            end
            KIND_FWD: begin
                if (r_day >= w_len_cur) begin
                    if (r_month < MONTHS) begin
                        n_month = r_month + 1'b1;
                        n_day   = DAY_MIN;
                    end else if (r_year < YEAR_MAX) begin
                        n_year  = r_year + 1'b1;
                        n_month = MONTH_MIN;
                        n_day   = DAY_MIN;
                        if (r_mod100 == MOD100_MAX) begin
                            n_mod100 = '0;
                            n_cent4  = r_cent4 + 1'b1;
                        end else begin
                            n_mod100 = r_mod100 + 1'b1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end else begin
                    n_day = r_day + 1'b1;
                end
            end
            KIND_BACK: begin
                if (r_day <= DAY_MIN) begin
                    if (r_month > MONTH_MIN) begin
                        n_month = r_month - 1'b1;
                        n_day   = month_len(r_month - 1'b1, w_leap_cur);
                    end else if (r_year > YEAR_MIN) begin
                        n_year  = r_year - 1'b1;
                        n_month = MONTHS;
                        n_day   = DAY_LONG;
                        if (r_mod100 == '0) begin
                            n_mod100 = MOD100_MAX;
                            n_cent4  = r_cent4 - 1'b1;
                        end else begin
                            n_mod100 = r_mod100 - 1'b1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end else begin
                    n_day = r_day - 1'b1;
                end
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    // flags of the new date
    assign n_leap      = leap_of(n_year[1:0], n_mod100, n_cent4);
    assign n_month_end = (n_day == month_len(n_month, n_leap));

    // date state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= YEAR_MIN;
            r_month  <= MONTH_MIN;
            r_day    <= DAY_MIN;
            r_mod100 <= 7'd1;
            r_cent4  <= '0;
        end else if (w_fire) begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_mod100 <= n_mod100;
            r_cent4  <= n_cent4;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_cmd_rdy) begin
            r_out_vld <= i_cmd_vld;
        end
        if (w_fire) begin
            r_out_year      <= n_year;
            r_out_month     <= n_month;
            r_out_day       <= n_day;
            r_out_leap      <= n_leap;
            r_out_month_end <= n_month_end;
            r_out_err       <= n_err;
        end
    end

    assign o_out_vld   = r_out_vld;
    assign o_year      = r_out_year;
    assign o_month     = r_out_month;
    assign o_day       = r_out_day;
    assign o_leap      = r_out_leap;
    assign o_month_end = r_out_month_end;
    assign o_err       = r_out_err;

    // held date stays a real calendar date
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_MIN) && (r_month <= MONTHS))
        else $error("held month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day >= DAY_MIN) && (r_day <= w_len_cur))
        else $error("held day out of range for its month");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX))
        else $error("held year out of range");

    // an error result leaves the held date untouched
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_err) |=> ((r_year == $past(r_year)) && (r_month == $past(r_month))
                               && (r_day == $past(r_day))))
        else $error("date changed on an error item");

endmodule

/* hdl/calendar_date_up_down_counter_unit.sv */
// top level of the gregorian calendar date up/down counter
//
// One date, 0001-01-01 to 9999-12-31, is held. Each input item loads a new
// date, steps forward a day or steps back a day; each yields one result
// item with the held date after the item, leap and month-end flags and an
// error flag. An invalid load or a step out of range flags an error and
// keeps the date; mode 3 keeps the date without error.
// Input channel i_s_*: tuser carries the mode, tdata the load fields.
// Output channel o_m_*: tdata carries the date and flags, tuser the error.
// An accepted item passes front stage a, front stage b (check), the item
// queue and the output register before its result is valid.
// Throughput: one item per cycle while i_m_tready stays high; the date
// update loops combinationally through the held date in the back end.
// A stalled receiver first fills the output register, then the item queue
// (QUEUE_DEPTH_P entries) and the two front stages before o_s_tready drops.
// Synchronous reset sets the date to 0001-01-01 and empties all stages.
module calendar_date_up_down_counter_unit import cdcnt_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // load_year, load_month, load_day, zero pad
    input  logic [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // cur_year, cur_month, cur_day, leap_flag,
                                     // month_end_flag, zero pad
    output logic        o_m_tuser    // error_flag
);

    logic                q_push_vld;
    logic                q_push_rdy;
    t_cmd                q_push_cmd;
    logic                q_pop_vld;
    logic                q_pop_rdy;
    t_cmd                q_pop_cmd;
    logic [YEAR_W-1:0]   w_year;
    logic [MONTH_W-1:0]  w_month;
    logic [DAY_W-1:0]    w_day;
    logic                w_leap;
    logic                w_month_end;

    // accept and classify
    cdcnt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_mode    (i_s_tuser),
        .i_year    (i_s_tdata[13:0]),
        .i_month   (i_s_tdata[17:14]),
        .i_day     (i_s_tdata[22:18]),
        .o_cmd_vld (q_push_vld),
        .o_cmd     (q_push_cmd),
        .i_cmd_rdy (q_push_rdy)
    );

    // decoupling queue
    cdcnt_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (q_push_vld),
        .o_push_rdy (q_push_rdy),
        .i_push_cmd (q_push_cmd),
        .o_pop_vld  (q_pop_vld),
        .i_pop_rdy  (q_pop_rdy),
        .o_pop_cmd  (q_pop_cmd)
    );

    // date update and result register
    cdcnt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (q_pop_vld),
        .o_cmd_rdy   (q_pop_rdy),
        .i_cmd       (q_pop_cmd),
        .o_out_vld   (o_m_tvalid),
        .i_out_rdy   (i_m_tready),
        .o_year      (w_year),
        .o_month     (w_month),
        .o_day       (w_day),
        .o_leap      (w_leap),
        .o_month_end (w_month_end),
        .o_err       (o_m_tuser)
    );

    // result packing
    assign o_m_tdata = {7'd0, w_month_end, w_leap, w_day, w_month, w_year};

endmodule
